### hw/rtl/gtp_pkg.sv
// Shared types, constants and small functions for the go-to-pose controller.
// Used by gtp_cordic, gtp_mul and go_to_pose_controller; depends on nothing.
package gtp_pkg;

	// CORDIC datapath widths
	localparam int XY_W   = 48;  // dx, dy shifted up by 12, plus gain growth
	localparam int Z_W    = 33;  // angle accumulator, Q2.30
	localparam int ITER_W = 5;   // iteration index, table has 24 entries
	localparam int MAX_STEPS = 24;

	// shared multiplier operand and product widths
	localparam int MA_W = 25;
	localparam int MB_W = 33;
	localparam int MP_W = MA_W + MB_W;

	localparam int DIST_W = 38;

	localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 33'sd1686629713;
	localparam logic signed [MB_W-1:0] INV_K_Q16   = 33'sd39797;
	localparam logic signed [16:0]     PI_Q12      = 17'sd12868;
	localparam logic signed [16:0]     TWO_PI_Q12  = 17'sd25736;

	// register indexes of the configuration port
	localparam logic [2:0] REG_GOAL_X      = 3'd0;
	localparam logic [2:0] REG_GOAL_Y      = 3'd1;
	localparam logic [2:0] REG_TARGET_HEAD = 3'd2;
	localparam logic [2:0] REG_DIST_TOL    = 3'd3;
	localparam logic [2:0] REG_HEAD_TOL    = 3'd4;
	localparam logic [2:0] REG_LIN_GAIN    = 3'd5;
	localparam logic [2:0] REG_SPEED_LIM   = 3'd6;
	localparam logic [2:0] REG_TURN_GAIN   = 3'd7;

	// status codes on the result channel
	localparam logic [1:0] STAT_POSITION = 2'd0;
	localparam logic [1:0] STAT_ORIENT   = 2'd1;
	localparam logic [1:0] STAT_REACHED  = 2'd2;
	localparam logic [1:0] STAT_CANCELED = 2'd3;

	typedef enum logic [1:0] {
		GS_ACTIVE   = 2'd0,
		GS_REACHED  = 2'd2,
		GS_CANCELED = 2'd3
	} goal_state_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_CORDIC,
		SQ_MHI,
		SQ_DIST,
		SQ_PHASE,
		SQ_MTURN,
		SQ_MSPD,
		SQ_SPD,
		SQ_OUT
	} seq_state_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [Z_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0:  v = 33'sd843314856;
			5'd1:  v = 33'sd497837829;
			5'd2:  v = 33'sd263043836;
			5'd3:  v = 33'sd133525158;
			5'd4:  v = 33'sd67021686;
			5'd5:  v = 33'sd33543515;
			5'd6:  v = 33'sd16775850;
			5'd7:  v = 33'sd8388437;
			5'd8:  v = 33'sd4194282;
			5'd9:  v = 33'sd2097149;
			5'd10: v = 33'sd1048575;
			5'd11: v = 33'sd524287;
			5'd12: v = 33'sd262143;
			5'd13: v = 33'sd131071;
			5'd14: v = 33'sd65535;
			5'd15: v = 33'sd32767;
			5'd16: v = 33'sd16383;
			5'd17: v = 33'sd8191;
			5'd18: v = 33'sd4095;
			5'd19: v = 33'sd2047;
			5'd20: v = 33'sd1023;
			5'd21: v = 33'sd511;
			5'd22: v = 33'sd255;
			5'd23: v = 33'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

	// one correction each way covers every difference of two 15-bit angles
	function automatic logic signed [15:0] wrap_angle(input logic signed [16:0] e);
		logic signed [16:0] r;
		if (e > PI_Q12)
			r = e - TWO_PI_Q12;
		else if (e < -PI_Q12)
			r = e + TWO_PI_Q12;
		else
			r = e;
		return r[15:0];
	endfunction

endpackage

### hw/rtl/go_to_pose_controller.sv
// Top level of the go-to-pose controller: configuration, sequencer, output stage.
// Depends on gtp_pkg, gtp_cordic and gtp_mul.

// One pose beat in gives one velocity command beat out. An active goal runs the
// offset to the target through an iterative CORDIC vectoring unit (one micro-rotation
// per clock), then through a single shared multiplier for distance scaling, turn
// and speed, so an item keeps s_tready low from acceptance until it leaves the
// output state; no new pose beat is taken before then. A beat that reaches the
// goal skips the turn and speed steps (MTURN, MSPD, SPD) and goes from PHASE
// straight to OUT. Items arriving while reached or canceled is latched need no
// arithmetic and go from IDLE straight to OUT. m_tvalid rises in the same cycle
// as s_tready, when the item leaves the output state and the block turns idle.
// The result sits in an output register, so a new pose beat may be taken
// while the previous command still waits for m_tready; the block only stalls at
// the end of an item if that register is still full. Status on m_tuser: 0 driving
// to position, 1 turning to the final heading, 2 reached, 3 canceled. Reached and
// canceled hold (zero velocity) until a beat with new_goal set. Configuration
// writes land at once and must only be issued while the block is idle.
module go_to_pose_controller #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// pose stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // pose_x [31:0], pose_y [63:32], pose_heading [78:64]
	input  logic [1:0]  s_tuser,   // cancel_request [0], new_goal [1]
	// command stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // forward_speed [15:0], turn_rate [31:16]
	output logic [1:0]  m_tuser    // status [1:0]
);

	// configuration registers
	logic signed [31:0] goal_x_q, goal_y_q;
	logic signed [14:0] target_head_q;
	logic [30:0]        dist_tol_q;
	logic [13:0]        head_tol_q;
	logic [14:0]        lin_gain_q, speed_lim_q, turn_gain_q;

	gtp_pkg::seq_state_t  state_q, state_d;
	gtp_pkg::goal_state_t goal_state_q, gs_fresh, gs_acc;

	logic accept, latched, cordic_start, cordic_done, out_free;

	logic signed [31:0] pose_x, pose_y;
	logic signed [14:0] pose_head;
	logic               cancel_req, new_goal;
	logic signed [32:0] dx, dy;

	logic signed [gtp_pkg::XY_W-1:0] cx;
	logic signed [gtp_pkg::Z_W-1:0]  cz;

	logic signed [gtp_pkg::MA_W-1:0] mul_a;
	logic signed [gtp_pkg::MB_W-1:0] mul_b;
	logic signed [gtp_pkg::MP_W-1:0] prod, acc_q;

	// working registers
	logic signed [14:0]             ph_q, bearing_q;
	logic signed [gtp_pkg::DIST_W-1:0] dist_q, dist_d;
	logic signed [15:0]             err_q, err_d, err_abs;
	logic                           pos_q, pos_d, reach;
	logic signed [16:0]             diff;
	logic signed [gtp_pkg::MB_W-1:0] dist_c;

	logic signed [65:0]             dsum;
	logic signed [gtp_pkg::Z_W-1:0] bsum;
	logic signed [gtp_pkg::MP_W-1:0] tsum, ssum;
	logic signed [45:0]             tsh;
	logic signed [41:0]             ssh;
	logic signed [15:0]             turn_sat, speed_min;

	logic signed [15:0] res_speed_q, res_turn_q;
	logic [1:0]         res_status_q;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	assign pose_x     = $signed(s_tdata[31:0]);
	assign pose_y     = $signed(s_tdata[63:32]);
	assign pose_head  = $signed(s_tdata[78:64]);
	assign cancel_req = s_tuser[0];
	assign new_goal   = s_tuser[1];

	assign s_tready = (state_q == gtp_pkg::SQ_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// new_goal clears the latch first, then cancel may latch again in the same beat
	always_comb begin
		gs_fresh = new_goal ? gtp_pkg::GS_ACTIVE : goal_state_q;
		gs_acc   = (gs_fresh == gtp_pkg::GS_ACTIVE && cancel_req) ?
		           gtp_pkg::GS_CANCELED : gs_fresh;
	end
	assign latched      = (gs_acc != gtp_pkg::GS_ACTIVE);
	assign cordic_start = accept && !latched;

	assign dx = $signed({goal_x_q[31], goal_x_q}) - $signed({pose_x[31], pose_x});
	assign dy = $signed({goal_y_q[31], goal_y_q}) - $signed({pose_y[31], pose_y});

	gtp_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.dx     (dx),
		.dy     (dy),
		.done   (cordic_done),
		.x_out  (cx),
		.z_out  (cz)
	);

	gtp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// shared multiplier operands per sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			gtp_pkg::SQ_CORDIC: begin
				// low 24 bits of magnitude times 1/K
				mul_a = $signed({1'b0, cx[23:0]});
				mul_b = gtp_pkg::INV_K_Q16;
			end
			gtp_pkg::SQ_MHI: begin
				mul_a = $signed({cx[47], cx[47:24]});
				mul_b = gtp_pkg::INV_K_Q16;
			end
			gtp_pkg::SQ_MTURN: begin
				mul_a = $signed({10'd0, turn_gain_q});
				mul_b = $signed({{17{err_q[15]}}, err_q});
			end
			gtp_pkg::SQ_MSPD: begin
				mul_a = $signed({10'd0, lin_gain_q});
				mul_b = dist_c;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// arithmetic around the multiplier
	always_comb begin
		// distance: (hi << 24) + lo, rounded, Q16.16
		dsum   = $signed({prod[41:0], 24'd0}) + $signed({{8{acc_q[57]}}, acc_q})
		         + 66'sd134217728;
		dist_d = dsum[65:28];
		bsum   = cz + 33'sd131072;

		// beyond 2^31 the speed cap always wins, so the operand may be clamped
		dist_c = (dist_q > 38'sd2147483648) ? 33'sd2147483648 : dist_q[32:0];

		pos_d = (dist_q > $signed({7'd0, dist_tol_q}));
		if (pos_d)
			diff = $signed({{2{bearing_q[14]}}, bearing_q}) - $signed({{2{ph_q[14]}}, ph_q});
		else
			diff = $signed({{2{target_head_q[14]}}, target_head_q})
			       - $signed({{2{ph_q[14]}}, ph_q});
		err_d   = gtp_pkg::wrap_angle(diff);
		err_abs = err_d[15] ? -err_d : err_d;
		reach   = !pos_d && (err_abs < $signed({2'd0, head_tol_q}));

		tsum = prod + 58'sd2048;
		tsh  = tsum[57:12];
		if (tsh > 46'sd32767)
			turn_sat = 16'sd32767;
		else if (tsh < -46'sd32768)
			turn_sat = -16'sd32768;
		else
			turn_sat = tsh[15:0];

		ssum = prod + 58'sd32768;
		ssh  = ssum[57:16];
		if (ssh > $signed({27'd0, speed_lim_q}))
			speed_min = $signed({1'b0, speed_lim_q});
		else
			speed_min = ssh[15:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gtp_pkg::SQ_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gtp_pkg::SQ_IDLE: begin
				if (accept)
					state_d = latched ? gtp_pkg::SQ_OUT : gtp_pkg::SQ_CORDIC;
			end
			gtp_pkg::SQ_CORDIC: begin
				if (cordic_done)
					state_d = gtp_pkg::SQ_MHI;
			end
			gtp_pkg::SQ_MHI:   state_d = gtp_pkg::SQ_DIST;
			gtp_pkg::SQ_DIST:  state_d = gtp_pkg::SQ_PHASE;
			gtp_pkg::SQ_PHASE: state_d = reach ? gtp_pkg::SQ_OUT : gtp_pkg::SQ_MTURN;
			gtp_pkg::SQ_MTURN: state_d = gtp_pkg::SQ_MSPD;
			gtp_pkg::SQ_MSPD:  state_d = gtp_pkg::SQ_SPD;
			gtp_pkg::SQ_SPD:   state_d = gtp_pkg::SQ_OUT;
			gtp_pkg::SQ_OUT: begin
				if (out_free)
					state_d = gtp_pkg::SQ_IDLE;
			end
			default: state_d = gtp_pkg::SQ_IDLE;
		endcase
	end

	// configuration and goal latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			target_head_q <= '0;
			dist_tol_q    <= 31'd6554;
			head_tol_q    <= 14'd205;
			lin_gain_q    <= 15'd2048;
			speed_lim_q   <= 15'd2048;
			turn_gain_q   <= 15'd4096;
			goal_state_q  <= gtp_pkg::GS_ACTIVE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gtp_pkg::REG_GOAL_X:      goal_x_q      <= $signed(cfg_data);
					gtp_pkg::REG_GOAL_Y:      goal_y_q      <= $signed(cfg_data);
					gtp_pkg::REG_TARGET_HEAD: target_head_q <= $signed(cfg_data[14:0]);
					gtp_pkg::REG_DIST_TOL:    dist_tol_q    <= cfg_data[30:0];
					gtp_pkg::REG_HEAD_TOL:    head_tol_q    <= cfg_data[13:0];
					gtp_pkg::REG_LIN_GAIN:    lin_gain_q    <= cfg_data[14:0];
					gtp_pkg::REG_SPEED_LIM:   speed_lim_q   <= cfg_data[14:0];
					gtp_pkg::REG_TURN_GAIN:   turn_gain_q   <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (accept)
				goal_state_q <= gs_acc;
			else if (state_q == gtp_pkg::SQ_PHASE && reach)
				goal_state_q <= gtp_pkg::GS_REACHED;
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			ph_q <= pose_head;
			if (latched) begin
				res_speed_q  <= '0;
				res_turn_q   <= '0;
				res_status_q <= gs_acc;
			end
		end
		case (state_q)
			gtp_pkg::SQ_MHI: acc_q <= prod;
			gtp_pkg::SQ_DIST: begin
				dist_q    <= dist_d;
				bearing_q <= bsum[32:18];
			end
			gtp_pkg::SQ_PHASE: begin
				err_q <= err_d;
				pos_q <= pos_d;
				if (reach) begin
					res_speed_q  <= '0;
					res_turn_q   <= '0;
					res_status_q <= gtp_pkg::STAT_REACHED;
				end
			end
			gtp_pkg::SQ_MSPD: res_turn_q <= turn_sat;
			gtp_pkg::SQ_SPD: begin
				res_speed_q  <= pos_q ? speed_min : 16'sd0;
				res_status_q <= pos_q ? gtp_pkg::STAT_POSITION : gtp_pkg::STAT_ORIENT;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == gtp_pkg::SQ_OUT && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == gtp_pkg::SQ_OUT && out_free) begin
			m_tdata_q <= {res_turn_q, res_speed_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// one item at a time: a taken pose beat closes the input until the item is done
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("pose beat accepted while an item was in progress");

	a_latched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == gtp_pkg::STAT_REACHED || m_tuser == gtp_pkg::STAT_CANCELED))
		|-> (m_tdata == 32'd0))
		else $error("reached or canceled command with nonzero velocity");

	a_orient_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == gtp_pkg::STAT_ORIENT) |-> (m_tdata[15:0] == 16'd0))
		else $error("forward speed nonzero while turning to final heading");

	a_speed_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[15])
		else $error("negative forward speed");

endmodule

### hw/rtl/gtp_mul.sv
// Shared signed multiplier with registered product.
// Depends on gtp_pkg for operand widths.
module gtp_mul (
	input  logic                             clk,
	input  logic signed [gtp_pkg::MA_W-1:0]  a,
	input  logic signed [gtp_pkg::MB_W-1:0]  b,
	output logic signed [gtp_pkg::MP_W-1:0]  p
);

	logic signed [gtp_pkg::MP_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### hw/rtl/gtp_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per clock.
// Depends on gtp_pkg for widths and the arctangent table.
module gtp_cordic #(
	parameter int STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [32:0]               dx,
	input  logic signed [32:0]               dy,
	output logic                             done,
	output logic signed [gtp_pkg::XY_W-1:0]  x_out,
	output logic signed [gtp_pkg::Z_W-1:0]   z_out
);

	localparam int NSTEPS = (STEPS > gtp_pkg::MAX_STEPS) ? gtp_pkg::MAX_STEPS : STEPS;
	localparam logic [gtp_pkg::ITER_W-1:0] LAST = gtp_pkg::ITER_W'(NSTEPS - 1);

	logic signed [gtp_pkg::XY_W-1:0] x_q, y_q, xs, ys, x0, y0, dx_s, dy_s;
	logic signed [gtp_pkg::Z_W-1:0]  z_q, z0, at;
	logic [gtp_pkg::ITER_W-1:0]      iter_q;
	logic                            busy_q, done_q;

	// quarter-turn pre-rotation brings the vector into the right half-plane
	always_comb begin
		dx_s = $signed({{3{dx[32]}}, dx, 12'd0});
		dy_s = $signed({{3{dy[32]}}, dy, 12'd0});
		if (dx[32]) begin
			if (!dy[32]) begin
				x0 = dy_s;
				y0 = -dx_s;
				z0 = gtp_pkg::HALF_PI_Q30;
			end else begin
				x0 = -dy_s;
				y0 = dx_s;
				z0 = -gtp_pkg::HALF_PI_Q30;
			end
		end else begin
			x0 = dx_s;
			y0 = dy_s;
			z0 = '0;
		end
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		at = gtp_pkg::atan_q30(iter_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					iter_q <= iter_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign z_out = z_q;

endmodule

### tb/tb_top.sv
// Self-checking bench for go_to_pose_controller: pose beats in, velocity commands out.
// Each command is predicted by a local fixed-point model of the controller and checked
// in order. Depends on gtp_pkg and the controller RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_STEPS  = 16;
	// the limit covers one item, a stall on each side and the pause around register
	// writes, taken many times over
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;      // comfortably above the time one item takes
	localparam int RANDOM_END    = 1400;    // beats sent when the idling part stops
	localparam int STEADY_ITEMS  = 200;     // back-to-back beats at the end

	localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
	localparam longint INV_GAIN_Q16     = 64'sd39797;
	localparam longint PI_Q12_L         = 64'sd12868;
	localparam longint TWO_PI_Q12_L     = 64'sd25736;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [14:0] heading;
		logic               cancel;
		logic               new_goal;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] speed;
		logic signed [15:0] turn;
		logic [1:0]         status;
	} drive_cmd_t;

	typedef struct packed {
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [14:0] target_heading;
		logic [30:0]        dist_tol;
		logic [13:0]        head_tol;
		logic [14:0]        lin_gain;
		logic [14:0]        speed_limit;
		logic [14:0]        turn_gain;
	} goal_setup_t;

	// atan(2^-i) in Q2.30, floor of the exact value
	longint arctan_q30 [0:23] = '{
		843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437,
		4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047,
		1023, 511, 255, 127
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // pose_x [31:0], pose_y [63:32], pose_heading [78:64]
	logic [1:0]  s_tuser;   // cancel_request [0], new_goal [1]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // forward_speed [15:0], turn_rate [31:16]
	logic [1:0]  m_tuser;   // status [1:0]

	// predictor copy of the block's registers and goal state
	goal_setup_t setup_now;
	gtp_pkg::goal_state_t goal_now;

	drive_cmd_t pending_commands [$];   // commands owed by the block, oldest first
	int poses_sent;
	int commands_checked;
	int mismatches;
	int status_seen [4];
	int idle_odds;        // 0: no idling; up to 4: out of 8, chance of a gap per beat
	int quiet_cycles;

	go_to_pose_controller #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// bring an angle error back into plus or minus pi (Q3.12)
	function automatic longint fold_angle(input longint e);
		while (e > PI_Q12_L)
			e -= TWO_PI_Q12_L;
		while (e < -PI_Q12_L)
			e += TWO_PI_Q12_L;
		return e;
	endfunction

	// CORDIC vectoring of the goal offset: range in Q16.16, bearing in Q3.12
	function automatic void range_and_bearing(input longint dx, input longint dy,
			output longint range_q16, output longint bearing_q12);
		longint x, y, z, t, xs, ys;
		int i;
		x = dx * 64'sd4096;
		y = dy * 64'sd4096;
		z = 0;
		// left half plane: quarter turn first so the iterations converge
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = QUARTER_TURN_Q30;
			end else begin
				t = x; x = -y; y = t; z = -QUARTER_TURN_Q30;
			end
		end
		for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += arctan_q30[i];
			end else begin
				x -= ys; y += xs; z -= arctan_q30[i];
			end
		end
		range_q16   = (x * INV_GAIN_Q16 + (64'sd1 <<< 27)) >>> 28;
		bearing_q12 = (z + (64'sd1 <<< 17)) >>> 18;
	endfunction

	// command the block owes for one pose beat; advances the goal state
	function automatic drive_cmd_t predict_command(input pose_t p);
		drive_cmd_t c;
		longint range_q16, bearing, err, spd, heading;
		longint tol, htol, lin, lim, tgain, tx, ty, th;
		heading = $signed(p.heading);
		tx      = $signed(setup_now.goal_x);
		ty      = $signed(setup_now.goal_y);
		th      = $signed(setup_now.target_heading);
		tol     = setup_now.dist_tol;
		htol    = setup_now.head_tol;
		lin     = setup_now.lin_gain;
		lim     = setup_now.speed_limit;
		tgain   = setup_now.turn_gain;
		c.speed = '0;
		c.turn  = '0;
		// a new goal clears the latch first; a cancel in the same beat still wins
		if (p.new_goal)
			goal_now = gtp_pkg::GS_ACTIVE;
		if (goal_now == gtp_pkg::GS_ACTIVE && p.cancel)
			goal_now = gtp_pkg::GS_CANCELED;
		if (goal_now != gtp_pkg::GS_ACTIVE) begin
			c.status = goal_now;
		end else begin
			range_and_bearing(tx - $signed(p.x), ty - $signed(p.y), range_q16, bearing);
			if (range_q16 > tol) begin
				err = fold_angle(bearing - heading);
				spd = (lin * range_q16 + (64'sd1 <<< 15)) >>> 16;
				if (spd > lim)
					spd = lim;
				c.speed  = 16'(clamp16(spd));
				c.turn   = 16'(clamp16((tgain * err + 64'sd2048) >>> 12));
				c.status = gtp_pkg::STAT_POSITION;
			end else begin
				// close enough: stand still and turn to the goal heading
				err = fold_angle(th - heading);
				if ((err < 0 ? -err : err) < htol) begin
					goal_now = gtp_pkg::GS_REACHED;
					c.status = gtp_pkg::STAT_REACHED;
				end else begin
					c.turn   = 16'(clamp16((tgain * err + 64'sd2048) >>> 12));
					c.status = gtp_pkg::STAT_ORIENT;
				end
			end
		end
		return c;
	endfunction

	// ---------------------------------------------------------------- drivers

	function automatic int rand_span(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic pose_t pose_at(input logic signed [31:0] x, input logic signed [31:0] y,
			input int heading, input logic cancel, input logic new_goal);
		pose_t p;
		p.x        = x;
		p.y        = y;
		p.heading  = 15'(heading);
		p.cancel   = cancel;
		p.new_goal = new_goal;
		return p;
	endfunction

	// one pose beat; s_tvalid stays up afterwards unless a gap or a settle lowers it
	task automatic send_pose(input pose_t p);
		if (idle_odds != 0 && $urandom_range(1, 8) <= idle_odds) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, p.heading, p.y, p.x};
		s_tuser  <= {p.new_goal, p.cancel};
		do
			@(posedge clk);
		while (!s_tready);
		pending_commands.push_back(predict_command(p));
		poses_sent++;
	endtask

	// wait for every owed command, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all eight registers back to back; only called once settled
	task automatic load_setup(input goal_setup_t s);
		logic [31:0] word [8];
		int i;
		word[gtp_pkg::REG_GOAL_X]      = s.goal_x;
		word[gtp_pkg::REG_GOAL_Y]      = s.goal_y;
		word[gtp_pkg::REG_TARGET_HEAD] = {17'b0, s.target_heading};
		word[gtp_pkg::REG_DIST_TOL]    = {1'b0, s.dist_tol};
		word[gtp_pkg::REG_HEAD_TOL]    = {18'b0, s.head_tol};
		word[gtp_pkg::REG_LIN_GAIN]    = {17'b0, s.lin_gain};
		word[gtp_pkg::REG_SPEED_LIM]   = {17'b0, s.speed_limit};
		word[gtp_pkg::REG_TURN_GAIN]   = {17'b0, s.turn_gain};
		for (i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= word[i];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		setup_now = s;
	endtask

	function automatic goal_setup_t random_setup();
		goal_setup_t s;
		if ($urandom_range(0, 7) == 0) begin
			s.goal_x = $urandom;
			s.goal_y = $urandom;
		end else begin
			s.goal_x = rand_span(1 << 24);
			s.goal_y = rand_span(1 << 24);
		end
		// now and then a heading outside plus or minus pi
		s.target_heading = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'(rand_span(12868));
		case ($urandom_range(0, 5))
			0:       s.dist_tol = '0;
			1:       s.dist_tol = 31'($urandom);
			default: s.dist_tol = 31'($urandom_range(1, 1 << 17));
		endcase
		s.head_tol    = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 2000));
		s.lin_gain    = 15'($urandom);
		s.speed_limit = 15'($urandom);
		s.turn_gain   = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 8192));
		return s;
	endfunction

	// one goal run: approach, turn to the final heading, a few beats while latched.
	// Some runs are just a noise beat with every field random.
	task automatic drive_episode();
		pose_t p;
		int ox, oy, reach, half_tol, d, n, i;
		if ($urandom_range(0, 4) == 0) begin
			p.x        = $urandom;
			p.y        = $urandom;
			p.heading  = 15'($urandom);
			p.cancel   = 1'($urandom);
			p.new_goal = 1'($urandom);
			send_pose(p);
		end else begin
			// position phase, offset shrinking towards the goal
			ox = rand_span(1 << 22);
			oy = rand_span(1 << 22);
			n  = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				p.x        = setup_now.goal_x - ox;
				p.y        = setup_now.goal_y - oy;
				p.heading  = 15'(rand_span(12868));
				p.new_goal = (i == 0);
				p.cancel   = ($urandom_range(0, 40) == 0);
				send_pose(p);
				ox = ox >>> $urandom_range(1, 3);
				oy = oy >>> $urandom_range(1, 3);
			end
			// inside the distance tolerance, heading error halving each beat
			reach = (setup_now.dist_tol >= 31'd2097152) ? (1 << 20) : int'(setup_now.dist_tol >> 1);
			half_tol = setup_now.head_tol;
			half_tol = half_tol / 2;
			d = rand_span(12868);
			n = $urandom_range(1, 5);
			for (i = 0; i < n; i++) begin
				if (i == n - 1)
					d = rand_span(half_tol);
				p.x        = setup_now.goal_x - rand_span(reach);
				p.y        = setup_now.goal_y - rand_span(reach);
				p.heading  = 15'($signed(setup_now.target_heading) + d);
				p.new_goal = 1'b0;
				p.cancel   = ($urandom_range(0, 40) == 0);
				send_pose(p);
				d = d / 2;
			end
			// latched: anything goes, the command must stay zero
			n = $urandom_range(0, 2);
			for (i = 0; i < n; i++) begin
				p.x        = $urandom;
				p.y        = $urandom;
				p.heading  = 15'(rand_span(12868));
				p.new_goal = 1'b0;
				p.cancel   = ($urandom_range(0, 3) == 0);
				send_pose(p);
			end
		end
	endtask

	// ---------------------------------------------------------------- tests

	// reset register values: reached, latching, quadrants, out-of-range headings, cancel
	task automatic test_goal_latching();
		send_pose(pose_at(0, 0, 0, 1'b0, 1'b0));                       // on goal: reached
		send_pose(pose_at(32'sh50000, 32'sh30000, 1000, 1'b0, 1'b0));  // held reached
		send_pose(pose_at(32'sh10000, 0, 0, 1'b0, 1'b1));              // goal behind, dy zero
		send_pose(pose_at(32'sh7FFFFFFF, 32'sh80000000, -12868, 1'b0, 1'b0));
		send_pose(pose_at(32'sh80000000, 32'sh7FFFFFFF, 12868, 1'b0, 1'b0));
		send_pose(pose_at(32'sh20000, 32'sh20000, 0, 1'b0, 1'b0));     // dx and dy negative
		send_pose(pose_at(-32'sh20000, 32'sh20000, 0, 1'b0, 1'b0));    // dx positive, dy negative
		send_pose(pose_at(0, -32'sh20000, 0, 1'b0, 1'b0));             // dx zero
		send_pose(pose_at(1000, -1000, 16383, 1'b0, 1'b0));            // orientation, wraps up
		send_pose(pose_at(-1000, 0, -16384, 1'b0, 1'b0));              // orientation, wraps down
		send_pose(pose_at(0, 0, 100, 1'b0, 1'b0));                     // inside heading tolerance
		send_pose(pose_at(32'sh10000, 32'sh10000, 0, 1'b1, 1'b1));     // new goal and cancel
		send_pose(pose_at(0, 0, 0, 1'b1, 1'b0));                       // held canceled
		send_pose(pose_at(32'sh10000, 0, 0, 1'b0, 1'b1));
		send_pose(pose_at(32'sh10000, 0, 0, 1'b1, 1'b0));              // cancel while active
	endtask

	// every register at its limits
	task automatic test_register_extremes();
		goal_setup_t s;
		settle();
		s.goal_x         = 32'sh7FFFFFFF;
		s.goal_y         = 32'sh80000000;
		s.target_heading = 15'sd12868;
		s.dist_tol       = '0;
		s.head_tol       = '1;
		s.lin_gain       = '1;
		s.speed_limit    = '1;
		s.turn_gain      = '1;
		load_setup(s);
		send_pose(pose_at(32'sh80000000, 32'sh7FFFFFFF, -12868, 1'b0, 1'b1)); // widest offset
		send_pose(pose_at(0, 0, 0, 1'b0, 1'b0));
		send_pose(pose_at(32'sh7FFFFFFF, 32'sh80000000, 5000, 1'b0, 1'b0));   // on goal
		settle();
		s.goal_x         = '0;
		s.goal_y         = '0;
		s.target_heading = -15'sd12868;
		s.dist_tol       = '1;
		s.head_tol       = '0;
		s.lin_gain       = '0;
		s.speed_limit    = '0;
		s.turn_gain      = '0;
		load_setup(s);
		send_pose(pose_at(32'sh40000000, 0, 0, 1'b0, 1'b1));   // inside a huge tolerance
		send_pose(pose_at(0, 0, -12868, 1'b0, 1'b0));          // zero error never below zero
		send_pose(pose_at(32'sh80000000, 32'sh80000000, 0, 1'b0, 1'b0));
	endtask

	// random settings and goal runs, with idling on both sides
	task automatic test_random_goals();
		int phase_end;
		while (poses_sent < RANDOM_END) begin
			settle();
			load_setup(random_setup());
			idle_odds = $urandom_range(0, 4);
			phase_end = poses_sent + $urandom_range(100, 200);
			while (poses_sent < phase_end)
				drive_episode();
		end
	endtask

	// last stretch: no gaps, no stalls
	task automatic test_steady_stream();
		int phase_end;
		settle();
		load_setup(random_setup());
		idle_odds = 0;
		phase_end = poses_sent + STEADY_ITEMS;
		while (poses_sent < phase_end)
			drive_episode();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= gtp_pkg::REG_GOAL_X;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		idle_odds = 2;
		goal_now  = gtp_pkg::GS_ACTIVE;
		setup_now.goal_x         = '0;
		setup_now.goal_y         = '0;
		setup_now.target_heading = '0;
		setup_now.dist_tol       = 31'd6554;
		setup_now.head_tol       = 14'd205;
		setup_now.lin_gain       = 15'd2048;
		setup_now.speed_limit    = 15'd2048;
		setup_now.turn_gain      = 15'd4096;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_goal_latching();
		test_register_extremes();
		test_random_goals();
		test_steady_stream();
		settle();

		$display("summary: %0d pose beats, %0d commands checked, %0d mismatches",
			poses_sent, commands_checked, mismatches);
		$display("summary: status seen - position %0d, orientation %0d, reached %0d, canceled %0d",
			status_seen[gtp_pkg::STAT_POSITION], status_seen[gtp_pkg::STAT_ORIENT],
			status_seen[gtp_pkg::STAT_REACHED], status_seen[gtp_pkg::STAT_CANCELED]);
		if (mismatches == 0 && pending_commands.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// command sink: stalls in bursts while idling is on
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_odds != 0 && $urandom_range(1, 8) <= idle_odds) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each command beat with the oldest prediction
	always @(posedge clk) begin : check_commands
		drive_cmd_t want;
		drive_cmd_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.speed  = m_tdata[15:0];
			got.turn   = m_tdata[31:16];
			got.status = m_tuser;
			status_seen[got.status]++;
			commands_checked++;
			if (pending_commands.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("command beat with none owed: speed %0d turn %0d status %0d",
						got.speed, got.turn, got.status);
			end else begin
				want = pending_commands.pop_front();
				if (got.speed !== want.speed || got.turn !== want.turn ||
						got.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"command %0d wrong: expected speed %0d turn %0d status %0d,",
							" got speed %0d turn %0d status %0d"}, commands_checked,
							want.speed, want.turn, want.status,
							got.speed, got.turn, got.status);
				end
			end
		end
	end

	// watchdog: too long with no beat on any port means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
